// ===== rtl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern search unit.
// Depends on nothing; imported by the top level.
package wbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 5;
    localparam int POS_W       = $clog2(PATTERN_MAX);
    localparam int PWDATA_W    = 64;
    localparam int PADDR_W     = 6;
    localparam int REG_SEL_W   = 3;

    typedef logic [7:0]          byte_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [PWDATA_W-1:0] word_t;
    typedef logic [REG_SEL_W-1:0] reg_sel_t;

    // Register select codes, taken from paddr[5:3].
    localparam reg_sel_t REG_PATTERN_LOW  = 3'd0;
    localparam reg_sel_t REG_PATTERN_HIGH = 3'd1;
    localparam reg_sel_t REG_WILDCARD     = 3'd2;
    localparam reg_sel_t REG_LENGTH       = 3'd3;
    localparam reg_sel_t REG_REGION_BASE  = 3'd4;

    localparam addr_t ADDR_MAX = {ADDR_W{1'b1}};

endpackage

// ===== rtl/wildcard_byte_pattern_search_unit.sv =====
// Wildcard byte pattern search unit: top level, window, compare and result path.
// Depends on wbps_pkg (types, register codes, widths).
//
// Streams a memory region one byte per item and reports the leftmost window of
// pattern_length bytes that equals the configured pattern, where wildcard_mask
// bits mark positions that match any byte. One result item per region: found=1
// with region_base plus the match offset at the first match, or found=0 with
// address 0 on the final byte when no window matched. After a match the rest of
// the region is consumed silently; the final byte always closes the region and
// clears the window and count. The block takes one item every cycle: the byte
// window, count and all 16 compares are updated together, and the result goes
// to an output register backed by one skid entry, so input is held off only
// while both are full. Registers sit at byte address 8*i on the APB port
// (64-bit data) and may be written only while the block is idle; a
// pattern_length of 0 acts as 1 and values above 16 act as 16.
module wildcard_byte_pattern_search_unit
    import wbps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // byte stream
    input  logic          in_valid,
    output logic          in_stall,
    input  byte_t         data_byte,
    input  logic          last_byte,
    // results
    output logic          out_valid,
    input  logic          out_stall,
    output logic          found,
    output addr_t         match_address,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  word_t         pwdata,
    output word_t         prdata,
    output logic          pready
);

    // Configuration registers
    word_t                  pattern_low_reg;
    word_t                  pattern_high_reg;
    logic [PATTERN_MAX-1:0] wildcard_reg;
    len_t                   length_reg;
    addr_t                  region_base_reg;

    // Region state
    byte_t                  window_reg [PATTERN_MAX];
    addr_t                  bytes_seen_reg;
    logic                   reported_reg;

    // Output register and skid entry
    logic                   out_valid_reg;
    logic                   out_found_reg;
    addr_t                  out_addr_reg;
    logic                   skid_valid_reg;
    logic                   skid_found_reg;
    addr_t                  skid_addr_reg;

    // Datapath
    logic                   accept;
    logic                   cfg_write;
    reg_sel_t               reg_sel;
    byte_t                  window_next [PATTERN_MAX];
    pos_t                   len_m1;
    len_t                   len_full;
    addr_t                  bytes_seen_next;
    logic                   hit;
    logic                   res_valid;
    addr_t                  res_addr;
    logic                   out_free;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[PADDR_W-1 -: REG_SEL_W];
    assign cfg_write = psel && penable && pwrite;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign found         = out_found_reg;
    assign match_address = out_addr_reg;

    // Register read back
    always_comb
    begin
        case (reg_sel)
            REG_PATTERN_LOW:  prdata = pattern_low_reg;
            REG_PATTERN_HIGH: prdata = pattern_high_reg;
            REG_WILDCARD:     prdata = PWDATA_W'(wildcard_reg);
            REG_LENGTH:       prdata = PWDATA_W'(length_reg);
            REG_REGION_BASE:  prdata = PWDATA_W'(region_base_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp the pattern length into 1..PATTERN_MAX, kept as length minus one
    always_comb
    begin
        if (length_reg == '0)
            len_m1 = '0;
        else if (length_reg > len_t'(PATTERN_MAX))
            len_m1 = pos_t'(PATTERN_MAX - 1);
        else
            len_m1 = pos_t'(length_reg - len_t'(1));
        len_full = len_t'(len_m1) + len_t'(1);
    end

    // Window with the new byte shifted in: entry k is the byte k items ago
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];
    end

    // Saturating byte count
    assign bytes_seen_next = (bytes_seen_reg == ADDR_MAX) ? bytes_seen_reg
                                                          : bytes_seen_reg + addr_t'(1);

    // Compare every pattern position against its window byte in parallel.
    // Pattern byte k lines up with window entry len-1-k.
    always_comb
    begin
        logic [2*PWDATA_W-1:0] pattern_all;
        pos_t                  kpos;
        pos_t                  wpos;
        logic                  ok;

        pattern_all = {pattern_high_reg, pattern_low_reg};
        ok = (bytes_seen_next >= addr_t'(len_full));
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            kpos = pos_t'(k);
            wpos = len_m1 - kpos;
            if ((kpos <= len_m1) && !wildcard_reg[k]
                && (window_next[wpos] != pattern_all[8*k +: 8]))
                ok = 1'b0;
        end
        hit = ok && !reported_reg;
    end

    // Match start address; zero when the region closes without a match
    assign res_addr  = hit ? (region_base_reg + (bytes_seen_next - addr_t'(len_full)))
                           : '0;
    assign res_valid = accept && !reported_reg && (hit || last_byte);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            wildcard_reg     <= '0;
            length_reg       <= len_t'(1);
            region_base_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_PATTERN_LOW:  pattern_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pattern_high_reg <= pwdata;
                REG_WILDCARD:     wildcard_reg     <= pwdata[PATTERN_MAX-1:0];
                REG_LENGTH:       length_reg       <= pwdata[LEN_W-1:0];
                REG_REGION_BASE:  region_base_reg  <= pwdata[ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Region state: advance on each item until a match, clear at region end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
                window_reg[i] <= '0;
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                for (int i = 0; i < PATTERN_MAX; i++)
                    window_reg[i] <= '0;
                bytes_seen_reg <= '0;
                reported_reg   <= 1'b0;
            end
            else if (!reported_reg)
            begin
                for (int i = 0; i < PATTERN_MAX; i++)
                    window_reg[i] <= window_next[i];
                bytes_seen_reg <= bytes_seen_next;
                reported_reg   <= hit;
            end
        end
    end

    // Output register with one skid entry. A result lands in the skid entry
    // only when the output register is full and stalled; input is held off
    // while the skid entry is occupied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= res_valid;
        end
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_found_reg <= skid_found_reg;
                out_addr_reg  <= skid_addr_reg;
            end
            else if (res_valid)
            begin
                out_found_reg <= hit;
                out_addr_reg  <= res_addr;
            end
        end
        else if (res_valid)
        begin
            skid_found_reg <= hit;
            skid_addr_reg  <= res_addr;
        end
    end

endmodule

// ===== verif/wildcard_byte_pattern_search_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wildcard byte pattern search unit.
// Depends on wbps_pkg and wildcard_byte_pattern_search_unit; needs no other file.
module testbench
    import wbps_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1700;
    localparam int TOTAL_ITEMS  = 1850;

    // One search result as the block reports it.
    typedef struct packed {
        logic  found;
        addr_t address;
    } search_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    byte_t                data_byte = '0;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 found;
    addr_t                match_address;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    word_t                pwdata = '0;
    word_t                prdata;
    logic                 pready;

    wildcard_byte_pattern_search_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_address (match_address),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the search registers, updated at each register write.
    word_t       cfg_low  = '0;
    word_t       cfg_high = '0;
    logic [15:0] cfg_mask = '0;
    len_t        cfg_len  = len_t'(1);
    addr_t       cfg_base = '0;

    // Shadow of the search state: recent bytes (entry 0 newest), byte count
    // within the region, and whether this region already produced its match.
    byte_t window [PATTERN_MAX];
    addr_t seen_count  = '0;
    logic  match_given = 1'b0;

    // Results still owed by the block, oldest first.
    search_result_t pending_matches [$];

    int  fail_count      = 0;
    int  items_sent      = 0;
    int  regions_sent    = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  settings_used   = 0;
    int  cycle_count     = 0;
    int  hold_cycles     = 0;
    int  stall_left      = 0;
    bit  idling          = 1'b1;

    initial
    begin
        foreach (window[i])
            window[i] = '0;
    end

    // Clamp the programmed length: zero acts as one, anything past the
    // window depth acts as the full depth.
    function automatic int unsigned active_length();
        if (cfg_len == '0)
            return 1;
        if (cfg_len > PATTERN_MAX)
            return PATTERN_MAX;
        return cfg_len;
    endfunction

    function automatic byte_t pattern_at(int unsigned pos);
        logic [127:0] pat;
        pat = {cfg_high, cfg_low};
        return pat[pos*8 +: 8];
    endfunction

    // Advance the shadow state by one accepted byte and queue whatever
    // result that byte must produce.
    function automatic void predict_search(input byte_t b, input logic last);
        int unsigned    len;
        logic           hit;
        search_result_t res;
        if (!match_given)
        begin
            len = active_length();
            for (int k = PATTERN_MAX - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = b;
            // Saturate the count rather than wrap
            if (seen_count != ADDR_MAX)
                seen_count = seen_count + 1'b1;
            hit = (seen_count >= addr_t'(len));
            // Pattern byte 0 lines up with the oldest byte of the window
            for (int k = 0; k < len; k++)
                if (!cfg_mask[k] && window[len-1-k] != pattern_at(k))
                    hit = 1'b0;
            if (hit)
            begin
                res.found   = 1'b1;
                res.address = cfg_base + (seen_count - addr_t'(len));
                pending_matches.push_back(res);
                match_given = 1'b1;
            end
            else if (last)
            begin
                res = '0;
                pending_matches.push_back(res);
            end
        end
        // The final byte always closes the region, matched or not
        if (last)
        begin
            foreach (window[i])
                window[i] = '0;
            seen_count  = '0;
            match_given = 1'b0;
        end
    endfunction

    // Check each accepted result against the oldest owed one, then fold
    // the accepted input byte into the prediction. Both handshakes are
    // sampled at the same edge, before any drive from this edge lands.
    always @(posedge clk)
    begin : monitor
        search_result_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_matches.size() == 0)
                begin
                    $error("unexpected result: found=%0b match_address=%h",
                           found, match_address);
                    fail_count++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    results_checked++;
                    if (found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, found);
                        fail_count++;
                    end
                    if (match_address !== want.address)
                    begin
                        $error("match_address: expected %h, actual %h",
                               want.address, match_address);
                        fail_count++;
                    end
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                predict_search(data_byte, last_byte);
        end
    end

    // Result-side stall: a long hold when a test asks for one, otherwise
    // random bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 11);
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_matches.size());
            $display("** wildcard_byte_pattern_search_unit: FAILED **");
            $finish;
        end
    end

    // Offer one item, after an optional random gap, and hold it until the
    // block takes it. Valid is left high so the next item follows directly.
    task automatic send_item(input byte_t b, input logic last);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        if (last)
            regions_sent++;
    endtask

    // Drop valid, wait until every owed result is in, then let the block settle.
    task automatic settle_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the
    // edge where the access phase meets pready.
    task automatic write_reg(input reg_sel_t sel, input word_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (sel)
            REG_PATTERN_LOW:  cfg_low  = value;
            REG_PATTERN_HIGH: cfg_high = value;
            REG_WILDCARD:     cfg_mask = value[15:0];
            REG_LENGTH:       cfg_len  = value[LEN_W-1:0];
            REG_REGION_BASE:  cfg_base = value[ADDR_W-1:0];
            default: ;
        endcase
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Half of them pattern bytes, so partial and overlapping matches show up often.
    function automatic byte_t filler_byte();
        if ($urandom_range(0, 1) == 1)
            return pattern_at($urandom_range(0, active_length() - 1));
        return byte_t'($urandom);
    endfunction

    // Build one region and stream it. Most regions carry the pattern (with
    // random bytes under wildcards) between random filler; some carry a
    // near miss, some are shorter than the pattern, some are pure noise.
    task automatic send_region();
        byte_t       seq [$];
        int unsigned len;
        int unsigned kind;
        int unsigned start;
        int unsigned flip;
        len  = active_length();
        kind = $urandom_range(0, 9);
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8))
            seq.push_back(filler_byte());
        if (kind <= 7)
        begin
            start = seq.size();
            for (int k = 0; k < len; k++)
                seq.push_back(cfg_mask[k] ? byte_t'($urandom) : pattern_at(k));
            if (kind >= 6)
            begin
                // Break one random position, if it is a literal
                flip = $urandom_range(0, len - 1);
                if (!cfg_mask[flip])
                    seq[start+flip] ^= byte_t'(8'h01 << $urandom_range(0, 7));
            end
            repeat ($urandom_range(0, 6))
                seq.push_back(filler_byte());
        end
        else if (kind == 8)
        begin
            seq.delete();
            repeat ((len > 1) ? $urandom_range(1, len - 1) : 1)
                seq.push_back(byte_t'($urandom));
        end
        else
            repeat ($urandom_range(1, 12))
                seq.push_back(byte_t'($urandom));
        foreach (seq[i])
            send_item(seq[i], i == seq.size() - 1);
    endtask

    // Program a full setting; every sixth phase lands on each extreme.
    task automatic random_setting(input int phase);
        word_t       low;
        word_t       high;
        logic [15:0] mask;
        len_t        len;
        addr_t       base;
        low  = {$urandom, $urandom};
        high = {$urandom, $urandom};
        mask = 16'($urandom & $urandom & $urandom);
        len  = ($urandom_range(0, 1) == 1) ? len_t'($urandom_range(1, 4))
                                           : len_t'($urandom_range(1, 16));
        base = addr_t'({$urandom, $urandom});
        case (phase % 6)
            0:
            begin
                low  = '0;
                high = '0;
                mask = '0;
                len  = len_t'(1);
                base = '0;
            end
            1:
            begin
                low  = '1;
                high = '1;
                mask = '1;
                len  = len_t'(PATTERN_MAX);
                base = ADDR_MAX;
            end
            2: len = '0;
            3: len = len_t'($urandom_range(17, 31));
            4: mask = 16'($urandom);
            default: ;
        endcase
        write_reg(REG_PATTERN_LOW, low);
        write_reg(REG_PATTERN_HIGH, high);
        write_reg(REG_WILDCARD, word_t'(mask));
        write_reg(REG_LENGTH, word_t'(len));
        write_reg(REG_REGION_BASE, word_t'(base));
        settings_used++;
    endtask

    // Reset values: length 1, zero pattern, so a lone zero byte matches at 0.
    task automatic test_reset_defaults();
        send_item(8'h00, 1'b1);
        settle_idle();
    endtask

    // Corner cases, each on one or two short regions.
    task automatic test_directed_corners();
        // Length zero acts as one; a literal '?' byte must not act as a
        // wildcard; the address wraps past the top of the space; bytes after
        // the match give nothing, and the final one still closes the region.
        write_reg(REG_PATTERN_LOW, word_t'(8'h3F));
        write_reg(REG_PATTERN_HIGH, '1);
        write_reg(REG_WILDCARD, '0);
        write_reg(REG_LENGTH, '0);
        write_reg(REG_REGION_BASE, word_t'(ADDR_MAX));
        send_item(8'h12, 1'b0);
        send_item(8'h3F, 1'b0);
        send_item(8'h00, 1'b1);
        settle_idle();

        // Change the base in the middle of a region: the new base applies
        write_reg(REG_PATTERN_LOW, word_t'(16'h5AA5));
        write_reg(REG_LENGTH, word_t'(2));
        write_reg(REG_REGION_BASE, word_t'(48'h1000));
        send_item(8'hA5, 1'b0);
        settle_idle();
        write_reg(REG_REGION_BASE, word_t'(48'h2000));
        send_item(8'h5A, 1'b1);
        settle_idle();

        // Oversized length acts as the full depth: a short region misses,
        // and a full-depth region matches on its final byte.
        write_reg(REG_WILDCARD, word_t'(16'hFFFF));
        write_reg(REG_LENGTH, word_t'(31));
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        for (int k = 0; k < PATTERN_MAX; k++)
            send_item(byte_t'(k * 17), k == PATTERN_MAX - 1);
        settle_idle();
    endtask

    // Hold results off for a long stretch while one-byte regions keep
    // coming, each producing a result, so the block must stall its input.
    // Then pause until everything owed has arrived, and stream six more regions.
    task automatic test_backpressure();
        write_reg(REG_WILDCARD, word_t'(16'h0001));
        write_reg(REG_LENGTH, word_t'(1));
        write_reg(REG_REGION_BASE, word_t'(addr_t'({$urandom, $urandom})));
        hold_cycles = LONG_HOLD;
        repeat (40)
            send_item(byte_t'($urandom), 1'b1);
        settle_idle();
        repeat (6)
            send_region();
        settle_idle();
    endtask

    // Random settings, each followed by a batch of regions.
    task automatic test_random_regions();
        int phase;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle_idle();
            idling = ($urandom_range(0, 3) != 0);
            random_setting(phase);
            repeat ($urandom_range(4, 12))
                send_region();
            phase++;
        end
        settle_idle();
    endtask

    // Close out at full rate with no idling on either side; always run at
    // least one batch so the run ends without gaps.
    task automatic test_quiet_tail();
        int phase;
        phase = 5;
        idling = 1'b0;
        do
        begin
            settle_idle();
            random_setting(phase);
            repeat ($urandom_range(4, 12))
                send_region();
            phase++;
        end
        while (items_sent < TOTAL_ITEMS);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_corners();
        test_backpressure();
        test_random_regions();
        test_quiet_tail();

        // Wait for every owed result, then watch for strays a little longer
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d bytes in %0d regions under %0d random settings (%0d writes);",
                 items_sent, regions_sent, settings_used, reg_writes);
        $display("checked %0d search results, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0)
            $display("** wildcard_byte_pattern_search_unit: PASSED **");
        else
            $display("** wildcard_byte_pattern_search_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wbps_pkg.sv
rtl/wildcard_byte_pattern_search_unit.sv
verif/wildcard_byte_pattern_search_unit_tb.sv
